@@ hdl/implicit_bst_accumulating_map_macros.svh @@
// Assertion macros used by the checker file of the accumulating map.
`ifndef IMPLICIT_BST_ACCUMULATING_MAP_MACROS_SVH
`define IMPLICIT_BST_ACCUMULATING_MAP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define IBST_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define IBST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/ibst_pkg.sv @@
`default_nettype none
package ibst_pkg;

   localparam int SLOTS    = 63;
   localparam int VALUE_W  = 31;
   localparam int WEIGHT_W = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;
   localparam int OP_W     = 2;
   localparam int ENTRY_W  = VALUE_W + WEIGHT_W;
   localparam int ADDR_W   = $clog2(SLOTS);
   // A child index can reach 2*SLOTS before it is found to be out of the store.
   localparam int IDX_W    = $clog2(2 * SLOTS + 1);
   // Levels of the smallest perfect tree that covers every slot.
   localparam int LEVELS   = $clog2(SLOTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_READOUT = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW  = 3'd0,
      ST_ACC  = 3'd1,
      ST_FULL = 3'd2,
      ST_ITEM = 3'd3,
      ST_DONE = 3'd4
   } status_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                       strobe;
      logic [VALUE_W-1:0]         value;
      logic signed [WEIGHT_W-1:0] weight;
      status_type                 status;
      logic [COUNT_W-1:0]         count;
      logic                       last;
   } rsp_type;

   // Maps an in-order rank (1 .. 2^LEVELS-1) of the perfect tree to its heap slot.
   // The lowest set bit of the rank gives the node's height above the leaves.
   function automatic logic [IDX_W-1:0] rank_to_slot(input logic [LEVELS-1:0] rank);
      logic [IDX_W-1:0] slot;
      logic             found;
      slot  = '0;
      found = 1'b0;
      for (int t = 0; t < LEVELS; t++) begin
         if (!found && rank[t]) begin
            found = 1'b1;
            slot  = IDX_W'((1 << (LEVELS - 1 - t)) - 1) + IDX_W'(rank >> (t + 1));
         end
      end
      return slot;
   endfunction

endpackage
`default_nettype wire

@@ hdl/implicit_bst_accumulating_map.sv @@
// Accumulating map kept as a binary search tree at heap positions in a slot RAM.
// A word is taken at a rising edge where start is high and busy is low; every
// result is shown for exactly one cycle with rsp_strobe high, and the receiver
// cannot hold it off. An insert walks one tree level per cycle through the RAM's
// registered read port: it probes the root, then compares against each occupied
// node on its path and gives a single result. A read-out steps through all
// 2^LEVELS - 1 in-order positions, one a cycle, reads each occupied slot once
// and sends its words in ascending value order back to back or with gaps, the
// final one marked by rsp_last. Clear and the unused operation code answer
// straight from the idle state. Occupancy bits sit in flip-flops, so the block is
// ready right after reset and clear needs no pass over the RAM. busy drops in
// the cycle in which the last result of a word is shown, so a new word may be
// taken while that result is on the ports.
`default_nettype none
module implicit_bst_accumulating_map import ibst_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic [VALUE_W-1:0]         req_search_value,
   input  wire logic signed [WEIGHT_W-1:0] req_add_weight,
   output logic                            rsp_strobe,
   output logic [VALUE_W-1:0]              rsp_out_value,
   output logic signed [WEIGHT_W-1:0]      rsp_out_weight,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [COUNT_W-1:0]              rsp_node_count,
   output logic                            rsp_last
);

   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] mem_rdata;
   rsp_type            rsp_in;
   rsp_type            rsp_ff;

   ibst_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_search_value (req_search_value),
      .req_add_weight   (req_add_weight),
      .mem_req          (mem_req),
      .mem_rdata        (mem_rdata),
      .rsp_next         (rsp_in)
   );

   ibst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   // Output register: only the strobe needs a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.value  <= rsp_in.value;
      rsp_ff.weight <= rsp_in.weight;
      rsp_ff.status <= rsp_in.status;
      rsp_ff.count  <= rsp_in.count;
      rsp_ff.last   <= rsp_in.last;
   end

   assign rsp_strobe     = rsp_ff.strobe;
   assign rsp_out_value  = rsp_ff.value;
   assign rsp_out_weight = rsp_ff.weight;
   assign rsp_status     = rsp_ff.status;
   assign rsp_node_count = rsp_ff.count;
   assign rsp_last       = rsp_ff.last;

endmodule
`default_nettype wire

@@ hdl/ibst_ram.sv @@
`default_nettype none
module ibst_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/ibst_ctrl.sv @@
`default_nettype none
module ibst_ctrl import ibst_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic [VALUE_W-1:0]         req_search_value,
   input  wire logic signed [WEIGHT_W-1:0] req_add_weight,
   output mem_req_type                     mem_req,
   input  wire logic [ENTRY_W-1:0]         mem_rdata,
   output rsp_type                         rsp_next
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PROBE = 6'b000010,
      S_CMP   = 6'b000100,
      S_SCAN  = 6'b001000,
      S_DRAIN = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [SLOTS-1:0]           used_ff, used_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic                       hold_valid_ff, hold_valid_in;
   logic [ENTRY_W-1:0]         hold_ff, hold_in;
   logic [IDX_W-1:0]           probe_ff, probe_in;
   logic [LEVELS-1:0]          rank_ff, rank_in;
   logic [VALUE_W-1:0]         val_ff, val_in;
   logic signed [WEIGHT_W-1:0] wt_ff, wt_in;

   logic [VALUE_W-1:0]         rd_value;
   logic signed [WEIGHT_W-1:0] rd_weight;
   logic signed [WEIGHT_W-1:0] acc_sum;
   logic                       go_right;
   logic                       match;
   logic [IDX_W-1:0]           next_idx;
   logic [IDX_W-1:0]           cand;
   logic                       cand_in_store;
   logic                       cand_used;
   logic [IDX_W-1:0]           scan_slot;
   logic                       scan_hit;

   assign busy = (state_ff != S_IDLE);

   assign rd_value  = mem_rdata[ENTRY_W-1 -: VALUE_W];
   assign rd_weight = $signed(mem_rdata[WEIGHT_W-1:0]);
   assign acc_sum   = rd_weight + wt_ff;
   assign go_right  = (rd_value < val_ff);
   assign match     = (rd_value == val_ff);
   assign next_idx  = (probe_ff << 1) + (go_right ? IDX_W'(2) : IDX_W'(1));

   // While comparing, the next slot on the path is probed in the same cycle.
   assign cand          = (state_ff == S_CMP) ? next_idx : probe_ff;
   assign cand_in_store = (cand < IDX_W'(SLOTS));
   assign cand_used     = cand_in_store && used_ff[cand[ADDR_W-1:0]];

   assign scan_slot = rank_to_slot(rank_ff);
   assign scan_hit  = (scan_slot < IDX_W'(SLOTS)) && used_ff[scan_slot[ADDR_W-1:0]];

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      rd_pend_in    = 1'b0;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      probe_in      = probe_ff;
      rank_in       = rank_ff;
      val_in        = val_ff;
      wt_in         = wt_ff;
      mem_req       = '0;
      rsp_next      = '0;

      // A node read during the read-out lands here in the cycle after it was issued. The word
      // held before it is sent now, since another node is known to follow it.
      if ((state_ff == S_SCAN || state_ff == S_DRAIN) && rd_pend_ff) begin
         if (hold_valid_ff) begin
            rsp_next.strobe = 1'b1;
            rsp_next.value  = hold_ff[ENTRY_W-1 -: VALUE_W];
            rsp_next.weight = $signed(hold_ff[WEIGHT_W-1:0]);
            rsp_next.status = ST_ITEM;
            rsp_next.count  = count_ff;
         end
         hold_in       = mem_rdata;
         hold_valid_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_INSERT: begin
                     val_in   = req_search_value;
                     wt_in    = req_add_weight;
                     probe_in = '0;
                     state_in = S_PROBE;
                  end
                  OP_READOUT: begin
                     rank_in       = LEVELS'(1);
                     hold_valid_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  OP_CLEAR: begin
                     used_in         = '0;
                     count_in        = '0;
                     rsp_next.strobe = 1'b1;
                     rsp_next.status = ST_DONE;
                     rsp_next.last   = 1'b1;
                  end
                  default: begin
                     rsp_next.strobe = 1'b1;
                     rsp_next.status = ST_DONE;
                     rsp_next.count  = count_ff;
                     rsp_next.last   = 1'b1;
                  end
               endcase
            end
         end
         S_PROBE, S_CMP: begin
            rsp_next.last  = 1'b1;
            rsp_next.count = count_ff;
            if (state_ff == S_CMP && match) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = probe_ff[ADDR_W-1:0];
               mem_req.wr_data = {rd_value, acc_sum};
               rsp_next.strobe = 1'b1;
               rsp_next.weight = acc_sum;
               rsp_next.status = ST_ACC;
               state_in        = S_IDLE;
            end else if (!cand_in_store) begin
               rsp_next.strobe = 1'b1;
               rsp_next.status = ST_FULL;
               state_in        = S_IDLE;
            end else if (!cand_used) begin
               mem_req.wr_en              = 1'b1;
               mem_req.wr_addr            = cand[ADDR_W-1:0];
               mem_req.wr_data            = {val_ff, wt_ff};
               used_in[cand[ADDR_W-1:0]]  = 1'b1;
               count_in                   = count_ff + COUNT_W'(1);
               rsp_next.strobe            = 1'b1;
               rsp_next.weight            = wt_ff;
               rsp_next.status            = ST_NEW;
               rsp_next.count             = count_ff + COUNT_W'(1);
               state_in                   = S_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cand[ADDR_W-1:0];
               probe_in        = cand;
               state_in        = S_CMP;
            end
         end
         S_SCAN: begin
            mem_req.rd_en   = scan_hit;
            mem_req.rd_addr = scan_slot[ADDR_W-1:0];
            rd_pend_in      = scan_hit;
            if (rank_ff == LEVELS'((1 << LEVELS) - 1)) begin
               state_in = S_DRAIN;
            end else begin
               rank_in = rank_ff + LEVELS'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            rsp_next.strobe = 1'b1;
            rsp_next.count  = count_ff;
            rsp_next.last   = 1'b1;
            if (hold_valid_ff) begin
               rsp_next.value  = hold_ff[ENTRY_W-1 -: VALUE_W];
               rsp_next.weight = $signed(hold_ff[WEIGHT_W-1:0]);
               rsp_next.status = ST_ITEM;
            end else begin
               rsp_next.status = ST_DONE;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         count_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
         rd_pend_ff    <= rd_pend_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      probe_ff <= probe_in;
      rank_ff  <= rank_in;
      val_ff   <= val_in;
      wt_ff    <= wt_in;
   end

endmodule
`default_nettype wire

@@ hdl/ibst_checker.sv @@
`default_nettype none
`include "implicit_bst_accumulating_map_macros.svh"
module ibst_checker import ibst_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic [OP_W-1:0]     req_operation,
   input wire logic                rsp_strobe,
   input wire logic [VALUE_W-1:0]  rsp_out_value,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [COUNT_W-1:0]  rsp_node_count,
   input wire logic                rsp_last
);

   logic is_item;
   logic done_empty;
   logic take_clear;
   logic take_insert;

   assign is_item     = (rsp_status == ST_ITEM);
   assign done_empty  = rsp_strobe && rsp_last && (rsp_status == ST_DONE) &&
                        (rsp_node_count == '0);
   assign take_clear  = start && !busy && (req_operation == OP_CLEAR);
   assign take_insert = start && !busy && (req_operation == OP_INSERT);

   // Only read-out node words can come without the last mark.
   `IBST_ASSERT_IMPLY(a_mid_word_is_item, clock, reset, rsp_strobe && !rsp_last, is_item)

   // A value is reported only by a read-out node word.
   `IBST_ASSERT_IMPLY(a_value_only_on_item, clock, reset, rsp_strobe && !is_item, rsp_out_value == '0)

   // The block is free again while the final word of an operation is shown.
   `IBST_ASSERT_IMPLY(a_last_frees_block, clock, reset, rsp_strobe && rsp_last, !busy)

   // A clear answers at once with an empty tree.
   `IBST_ASSERT_NEXT(a_clear_answer, clock, reset, take_clear, done_empty)

   // An insert always walks at least the root before it answers.
   `IBST_ASSERT_NEXT(a_insert_walks, clock, reset, take_insert, busy && !rsp_strobe)

endmodule

bind implicit_bst_accumulating_map ibst_checker u_checker (.*);
`default_nettype wire
